// ===== hw/rtl/bpfa_pkg.sv =====
// Shared types and constants of the bitmap page frame allocator.
`timescale 1ns / 1ps

package bpfa_pkg;

  localparam int ADDR_W     = 64;
  localparam int BASE_W     = 52;
  localparam int PAGES_W    = 13;
  localparam int COUNT_W    = 13;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 52;

  // The bitmap is held as words of this many bits.
  localparam int WORD_BITS = 64;
  localparam int WORD_LOG2 = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_USABLE_PAGES = 1'b1;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_OOM     = 2'd1,
    ST_BADFREE = 2'd2
  } status_e;

  typedef struct packed {
    logic                 found;
    logic [WORD_LOG2-1:0] pos;
  } ffz_res_t;

endpackage

// ===== hw/rtl/bitmap_page_frame_allocator.sv =====
// Top level of the bitmap first-fit page frame allocator.
`timescale 1ns / 1ps

// The allocator keeps one used bit per page frame in a memory of 64-bit words and handles
// one request at a time: in_ready_o is high only while the sequencer is idle. An allocate
// reads the bitmap one word per cycle from word zero, and the lowest-free-bit unit examines
// each word as it arrives; it scans at most ceil(min(usable_pages, MAX_FRAMES) / 64) words,
// out of memory costs the same full scan, and an allocate on an empty pool is answered
// without reading the bitmap. A free takes an address check, one word read and, if the
// frame was in use, a write-back; a free that fails the address check is answered without
// the read. A finished result sits in an output register, so the next transaction is
// taken while it waits. After reset the bitmap is cleared one word per cycle, all
// ceil(MAX_FRAMES / 64) words, before the first request is accepted; configuration
// writes are taken throughout.
module bitmap_page_frame_allocator #(
  parameter int MAX_FRAMES      = 4096,
  parameter int PAGE_BYTES_LOG2 = 12
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [bpfa_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bpfa_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             mode_i,
  input  logic [bpfa_pkg::ADDR_W-1:0]      frame_address_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [bpfa_pkg::ADDR_W-1:0]      granted_address_o,
  output logic [bpfa_pkg::STATUS_W-1:0]    status_o,
  output logic [bpfa_pkg::COUNT_W-1:0]     used_count_o
);
  import bpfa_pkg::*;

  localparam int WORDS   = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_AW = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int SCAN_W  = WORD_AW + WORD_LOG2;
  localparam int LIM_W   = $clog2(MAX_FRAMES + 1);
  localparam int CMP_W   = (LIM_W > PAGES_W) ? LIM_W : PAGES_W;
  localparam int CW      = (SCAN_W + 1 > CMP_W) ? SCAN_W + 1 : CMP_W;
  localparam int FRAME_W = ADDR_W - PAGE_BYTES_LOG2;
  localparam int DIFF_W  = (FRAME_W > BASE_W) ? FRAME_W : BASE_W;

  localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(WORDS - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_FCHK  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_EVAL  = 3'd4;
  localparam logic [2:0] S_GRANT = 3'd5;
  localparam logic [2:0] S_RESP  = 3'd6;

  logic [2:0]           state_q, state_d;
  logic [WORD_AW-1:0]   clr_q, clr_d;
  logic [COUNT_W-1:0]   count_q, count_d;
  logic [BASE_W-1:0]    base_q;
  logic [PAGES_W-1:0]   usable_q;
  logic                 out_valid_q, out_valid_d;

  logic                 mode_q, mode_d;
  logic [ADDR_W-1:0]    addr_q, addr_d;
  logic [WORD_AW-1:0]   word_q, word_d;
  logic [WORD_LOG2-1:0] bit_q, bit_d;
  logic [ADDR_W-1:0]    res_addr_q, res_addr_d;
  status_e              res_status_q, res_status_d;
  logic [ADDR_W-1:0]    out_addr_q;
  logic [STATUS_W-1:0]  out_status_q;
  logic [COUNT_W-1:0]   out_count_q;

  logic [WORD_BITS-1:0] bitmap_mem [WORDS];
  logic [WORD_BITS-1:0] rd_data_q;
  logic                 rd_en;
  logic [WORD_AW-1:0]   rd_addr;
  logic                 mem_we;
  logic [WORD_AW-1:0]   mem_wa;
  logic [WORD_BITS-1:0] mem_wd;

  logic [CMP_W-1:0]     limit;
  logic [CW-1:0]        word_start;
  logic [CW-1:0]        next_start;
  logic [CW-1:0]        remaining;
  logic                 scan_more;
  logic [WORD_BITS-1:0] scan_mask;
  logic [WORD_BITS-1:0] bit_onehot;
  ffz_res_t             ffz_res;

  logic [DIFF_W-1:0]    frame_ext;
  logic [DIFF_W-1:0]    base_ext;
  logic [DIFF_W-1:0]    diff;
  logic                 free_bad;
  logic [ADDR_W-1:0]    grant_addr;
  logic                 out_load;

  // Effective pool size is the configured page count capped at the map size.
  assign limit = (CMP_W'(usable_q) < CMP_W'(MAX_FRAMES)) ? CMP_W'(usable_q)
                                                         : CMP_W'(MAX_FRAMES);

  assign word_start = CW'({word_q, {WORD_LOG2{1'b0}}});
  assign next_start = word_start + CW'(WORD_BITS);
  assign scan_more  = next_start < CW'(limit);
  assign remaining  = CW'(limit) - word_start;
  assign scan_mask  = (remaining >= CW'(WORD_BITS)) ? {WORD_BITS{1'b1}}
                    : ~({WORD_BITS{1'b1}} << remaining[WORD_LOG2-1:0]);
  assign bit_onehot = WORD_BITS'(1) << bit_q;

  bpfa_ffz u_ffz (
    .word_i (rd_data_q),
    .mask_i (scan_mask),
    .res_o  (ffz_res)
  );

  assign frame_ext = DIFF_W'(addr_q[ADDR_W-1:PAGE_BYTES_LOG2]);
  assign base_ext  = DIFF_W'(base_q);
  assign diff      = frame_ext - base_ext;
  assign free_bad  = (|addr_q[PAGE_BYTES_LOG2-1:0]) || (frame_ext < base_ext)
                  || (diff >= DIFF_W'(limit));

  assign grant_addr = (ADDR_W'(base_q) + ADDR_W'({word_q, bit_q})) << PAGE_BYTES_LOG2;

  assign out_load = (state_q == S_RESP) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    count_d      = count_q;
    out_valid_d  = out_valid_q;
    mode_d       = mode_q;
    addr_d       = addr_q;
    word_d       = word_q;
    bit_d        = bit_q;
    res_addr_d   = res_addr_q;
    res_status_d = res_status_q;
    mem_we       = 1'b0;
    mem_wa       = word_q;
    mem_wd       = rd_data_q | bit_onehot;
    rd_en        = 1'b0;
    rd_addr      = word_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        mem_wd = '0;
        if (clr_q == LAST_WORD) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + WORD_AW'(1);
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          mode_d     = mode_i;
          addr_d     = frame_address_i;
          res_addr_d = '0;
          word_d     = '0;
          if (mode_i == MODE_FREE) begin
            state_d = S_FCHK;
          end else if (limit == '0) begin
            res_status_d = ST_OOM;
            state_d      = S_RESP;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_FCHK: begin
        if (free_bad) begin
          res_status_d = ST_BADFREE;
          state_d      = S_RESP;
        end else begin
          word_d  = diff[SCAN_W-1:WORD_LOG2];
          bit_d   = diff[WORD_LOG2-1:0];
          state_d = S_READ;
        end
      end
      S_READ: begin
        rd_en   = 1'b1;
        state_d = S_EVAL;
      end
      S_EVAL: begin
        if (mode_q == MODE_FREE) begin
          res_status_d = ST_OK;
          // Freeing a frame that is already free changes nothing.
          if (rd_data_q[bit_q]) begin
            mem_we = 1'b1;
            mem_wd = rd_data_q & ~bit_onehot;
            if (count_q != '0) begin
              count_d = count_q - COUNT_W'(1);
            end
          end
          state_d = S_RESP;
        end else if (ffz_res.found) begin
          bit_d   = ffz_res.pos;
          state_d = S_GRANT;
        end else if (scan_more) begin
          // Fetch the next word while this one is being ruled out.
          rd_en   = 1'b1;
          rd_addr = word_q + WORD_AW'(1);
          word_d  = word_q + WORD_AW'(1);
        end else begin
          res_status_d = ST_OOM;
          state_d      = S_RESP;
        end
      end
      S_GRANT: begin
        mem_we       = 1'b1;
        count_d      = count_q + COUNT_W'(1);
        res_addr_d   = grant_addr;
        res_status_d = ST_OK;
        state_d      = S_RESP;
      end
      S_RESP: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      base_q      <= '0;
      usable_q    <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_POOL_BASE:    base_q   <= cfg_wdata_i[BASE_W-1:0];
          CFG_USABLE_PAGES: usable_q <= cfg_wdata_i[PAGES_W-1:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    addr_q       <= addr_d;
    word_q       <= word_d;
    bit_q        <= bit_d;
    res_addr_q   <= res_addr_d;
    res_status_q <= res_status_d;
    if (out_load) begin
      out_addr_q   <= res_addr_q;
      out_status_q <= res_status_q;
      out_count_q  <= count_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      bitmap_mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_data_q <= bitmap_mem[rd_addr];
    end
  end

  assign in_ready_o        = (state_q == S_IDLE);
  assign out_valid_o       = out_valid_q;
  assign granted_address_o = out_addr_q;
  assign status_o          = out_status_q;
  assign used_count_o      = out_count_q;

endmodule

// ===== hw/rtl/bpfa_ffz.sv =====
// Lowest-free-bit search over one bitmap word, limited by a mask of valid frames.
`timescale 1ns / 1ps

module bpfa_ffz (
  input  logic [bpfa_pkg::WORD_BITS-1:0] word_i,
  input  logic [bpfa_pkg::WORD_BITS-1:0] mask_i,
  output bpfa_pkg::ffz_res_t             res_o
);
  import bpfa_pkg::*;

  logic [WORD_BITS-1:0] free_bits;

  assign free_bits = ~word_i & mask_i;

  always_comb begin
    res_o.found = |free_bits;
    res_o.pos   = '0;
    // Walk downwards so that the lowest free bit is the one left standing.
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (free_bits[b]) begin
        res_o.pos = WORD_LOG2'(b);
      end
    end
  end

endmodule

// ===== hw/rtl/bpfa_checker.sv =====
// Port-level assertions for the bitmap page frame allocator, bound to its top level.
`timescale 1ns / 1ps

module bpfa_checker #(
  parameter int PAGE_BYTES_LOG2 = 12
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [bpfa_pkg::ADDR_W-1:0]     granted_address_o,
  input logic [bpfa_pkg::STATUS_W-1:0]   status_o,
  input logic [bpfa_pkg::COUNT_W-1:0]    used_count_o
);
  import bpfa_pkg::*;

  // A stalled result must stay on the port unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(granted_address_o)
      && $stable(status_o) && $stable(used_count_o))
    else $error("result changed while stalled");

  // Only a successful allocate carries an address.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> granted_address_o == '0)
    else $error("failed request returned a non-zero address");

  a_page_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> granted_address_o[PAGE_BYTES_LOG2-1:0] == '0)
    else $error("granted address is not page aligned");

  // The sequencer works on one transaction at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready stayed high after a transaction was taken");

endmodule

bind bitmap_page_frame_allocator bpfa_checker #(
  .PAGE_BYTES_LOG2 (PAGE_BYTES_LOG2)
) u_bpfa_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .granted_address_o (granted_address_o),
  .status_o          (status_o),
  .used_count_o      (used_count_o)
);

// ===== dv/tb_bitmap_page_frame_allocator.sv =====
// Self-checking testbench for the bitmap page frame allocator.
`timescale 1ns / 1ps

module tb_bitmap_page_frame_allocator;
  import bpfa_pkg::*;

  localparam int MAX_FRAMES   = 4096;
  localparam int PAGE_LOG2    = 12;
  localparam int IDLE_PCT     = 34;
  localparam int RANDOM_ITEMS = 1730;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 80;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic                  mode_i;
  logic [ADDR_W-1:0]     frame_address_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [ADDR_W-1:0]     granted_address_o;
  logic [STATUS_W-1:0]   status_o;
  logic [COUNT_W-1:0]    used_count_o;

  // Set by the stimulus to remove all idling on both sides for a while.
  logic calm;
  // Asks the receiver for one long hold-off; the receiver clears it when done.
  logic rx_hold_req;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    status_e            status;
    logic [COUNT_W-1:0] count;
  } grant_t;

  // Mirrors the frame bitmap and the registers, predicts each result and
  // compares the block's results against the oldest outstanding prediction.
  class frame_ledger;
    bit                 used_map [MAX_FRAMES];
    logic [COUNT_W-1:0] in_use;
    logic [BASE_W-1:0]  base_frame;
    logic [PAGES_W-1:0] pages;
    grant_t             grants_due[$];
    int                 mismatches;
    int                 checked;
    int                 n_alloc;
    int                 n_oom;
    int                 n_free;
    int                 n_rejected;

    function new();
      foreach (used_map[i]) used_map[i] = 1'b0;
      in_use     = '0;
      base_frame = '0;
      pages      = '0;
      mismatches = 0;
      checked    = 0;
      n_alloc    = 0;
      n_oom      = 0;
      n_free     = 0;
      n_rejected = 0;
    endfunction

    function int unsigned pool_span();
      return (pages < MAX_FRAMES) ? int'(pages) : MAX_FRAMES;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_POOL_BASE) begin
        base_frame = data[BASE_W-1:0];
      end else begin
        pages = data[PAGES_W-1:0];
      end
    endfunction

    function void note_request(logic m, logic [ADDR_W-1:0] a);
      grant_t            g;
      int unsigned       lim;
      bit                found;
      logic [BASE_W-1:0] fr;
      logic [BASE_W-1:0] idx;
      lim      = pool_span();
      found    = 1'b0;
      g.addr   = '0;
      g.status = ST_OK;
      if (m == MODE_ALLOC) begin
        n_alloc++;
        for (int unsigned i = 0; i < lim; i++) begin
          if (!found && !used_map[i]) begin
            found       = 1'b1;
            used_map[i] = 1'b1;
            in_use      = in_use + 1'b1;
            // The sum is taken modulo 2^64 before and after the shift.
            g.addr      = ({12'd0, base_frame} + 64'(i)) << PAGE_LOG2;
          end
        end
        if (!found) begin
          g.status = ST_OOM;
          n_oom++;
        end
      end else begin
        n_free++;
        fr  = a[ADDR_W-1:PAGE_LOG2];
        idx = fr - base_frame;
        if (a[PAGE_LOG2-1:0] != '0 || fr < base_frame || idx >= lim) begin
          g.status = ST_BADFREE;
          n_rejected++;
        end else if (used_map[idx]) begin
          used_map[idx] = 1'b0;
          if (in_use != '0) in_use = in_use - 1'b1;
        end
      end
      g.count = in_use;
      grants_due.push_back(g);
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    function void check_result(logic [ADDR_W-1:0] a, logic [STATUS_W-1:0] s,
                               logic [COUNT_W-1:0] c);
      grant_t g;
      if (grants_due.size() == 0) begin
        flag($sformatf("unexpected result: granted %h status %0d count %0d", a, s, c));
        return;
      end
      g = grants_due.pop_front();
      checked++;
      if (a !== g.addr) begin
        flag($sformatf("result %0d granted_address: expected %h, got %h", checked, g.addr, a));
      end
      if (s !== g.status) begin
        flag($sformatf("result %0d status: expected %0d, got %0d", checked, g.status, s));
      end
      if (c !== g.count) begin
        flag($sformatf("result %0d used_count: expected %0d, got %0d", checked, g.count, c));
      end
    endfunction
  endclass

  frame_ledger ledger;
  int          n_settings;

  bitmap_page_frame_allocator #(
    .MAX_FRAMES      (MAX_FRAMES),
    .PAGE_BYTES_LOG2 (PAGE_LOG2)
  ) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .mode_i            (mode_i),
    .frame_address_i   (frame_address_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .granted_address_o (granted_address_o),
    .status_o          (status_o),
    .used_count_o      (used_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      ledger.check_result(granted_address_o, status_o, used_count_o);
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_hold_req) begin
        out_ready_i = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        rx_hold_req = 1'b0;
      end
      out_ready_i = calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    #10_000_000;
    $display("Timeout with %0d results outstanding", ledger.grants_due.size());
    $display("== FAIL ==");
    $finish;
  end

  // Entered and left at a falling edge; valid stays high after the transaction
  // so that back-to-back items need no second assignment in the same step.
  task automatic send_item(input logic m, input logic [ADDR_W-1:0] a);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      = 1'b1;
    mode_i          = m;
    frame_address_i = a;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    ledger.note_request(m, a);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (ledger.grants_due.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = data;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    ledger.set_register(idx, data);
  endtask

  task automatic set_pool(input logic [BASE_W-1:0] base, input logic [PAGES_W-1:0] n);
    drain();
    write_reg(CFG_POOL_BASE, base);
    write_reg(CFG_USABLE_PAGES, CFG_DATA_W'(n));
    n_settings++;
  endtask

  function automatic logic [ADDR_W-1:0] frame_addr(input logic [BASE_W-1:0] base, input int idx);
    return ({12'd0, base} + 64'(idx)) << PAGE_LOG2;
  endfunction

  task automatic random_item(input int alloc_pct);
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] fr;
    int unsigned       pick;
    a = {$urandom, $urandom};
    if ($urandom_range(99) < alloc_pct) begin
      send_item(MODE_ALLOC, a);
      return;
    end
    pick = $urandom_range(99);
    // First fit keeps used frames low, so aim most frees at frames up to two above the count.
    fr = {12'd0, ledger.base_frame} + 64'($urandom_range(0, ledger.in_use + 2));
    if (pick < 70) begin
      a = fr << PAGE_LOG2;
    end else if (pick < 78) begin
      a = (fr << PAGE_LOG2) | 64'($urandom_range(1, (1 << PAGE_LOG2) - 1));
    end else if (pick < 84) begin
      a = frame_addr(ledger.base_frame, ledger.pool_span() + $urandom_range(0, 3));
    end else if (pick < 92) begin
      a = frame_addr(ledger.base_frame, -$urandom_range(1, 3));
    end
    send_item(MODE_FREE, a);
  endtask

  initial begin
    logic [BASE_W-1:0]  base;
    logic [PAGES_W-1:0] n;
    int                 rand_sent;
    int                 phase;
    int                 phase_len;
    int                 alloc_pct;
    bit                 hold_issued;
    ledger          = new();
    n_settings      = 0;
    rand_sent       = 0;
    phase           = 0;
    hold_issued     = 1'b0;
    calm            = 1'b0;
    rx_hold_req     = 1'b0;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_POOL_BASE;
    cfg_wdata_i     = '0;
    in_valid_i      = 1'b0;
    mode_i          = MODE_ALLOC;
    frame_address_i = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Empty pool: allocation runs out at once and no free can land.
    set_pool('0, '0);
    send_item(MODE_ALLOC, '1);
    send_item(MODE_FREE, 64'h0);
    send_item(MODE_FREE, 64'h1);

    // Top of the frame range: grants wrap past 2^64, and the pool fills up.
    set_pool('1, 13'd3);
    repeat (4) send_item(MODE_ALLOC, '0);
    send_item(MODE_FREE, 64'hFFFF_FFFF_FFFF_F000);
    send_item(MODE_FREE, 64'hFFFF_FFFF_FFFF_F000);
    send_item(MODE_FREE, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(MODE_FREE, 64'h0000_0000_0000_1000);
    send_item(MODE_ALLOC, '0);

    // Full map size; frees at the limit, below the base and of idle frames.
    set_pool(52'd5, 13'd4096);
    repeat (2) send_item(MODE_ALLOC, '0);
    send_item(MODE_FREE, frame_addr(52'd5, 4096));
    send_item(MODE_FREE, frame_addr(52'd5, 4095));
    send_item(MODE_FREE, frame_addr(52'd5, -1));
    send_item(MODE_FREE, frame_addr(52'd5, 3));

    // Shrinking the pool strands frames above the new count.
    set_pool(52'd5, 13'd2);
    send_item(MODE_FREE, frame_addr(52'd5, 4));
    send_item(MODE_ALLOC, '0);
    send_item(MODE_FREE, frame_addr(52'd5, 1));

    while (rand_sent < RANDOM_ITEMS) begin
      case ($urandom_range(3))
        0: base = '0;
        1: base = '1 - BASE_W'($urandom_range(0, 200));
        2: base = BASE_W'({$urandom, $urandom});
        default: base = BASE_W'($urandom_range(0, 5000));
      endcase
      case ($urandom_range(9))
        0: n = '0;
        1: n = 13'd1;
        2: n = 13'd4096;
        3: n = PAGES_W'($urandom_range(64, 4096));
        default: n = PAGES_W'($urandom_range(2, 130));
      endcase
      if (phase == 1) begin
        base = '1;
        n    = 13'd4096;
      end
      set_pool(base, n);
      phase_len = $urandom_range(40, 140);
      alloc_pct = $urandom_range(35, 75);
      for (int k = 0; k < phase_len && rand_sent < RANDOM_ITEMS; k++) begin
        calm = (rand_sent >= 900 && rand_sent < 1150);
        // Hold the output early in a phase so that the sender keeps offering.
        if (k == 0 && !hold_issued && rand_sent >= 400) begin
          rx_hold_req = 1'b1;
          hold_issued = 1'b1;
        end
        random_item(alloc_pct);
        rand_sent++;
      end
      phase++;
    end

    drain();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    $display("Covered %0d allocations (%0d out of memory) and %0d frees (%0d rejected)",
             ledger.n_alloc, ledger.n_oom, ledger.n_free, ledger.n_rejected);
    $display("across %0d pool settings; %0d results checked, %0d mismatches.",
             n_settings, ledger.checked, ledger.mismatches);
    if (ledger.mismatches == 0 && ledger.grants_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/bpfa_pkg.sv
hw/rtl/bpfa_ffz.sv
hw/rtl/bitmap_page_frame_allocator.sv
hw/rtl/bpfa_checker.sv
dv/tb_bitmap_page_frame_allocator.sv
